### hw/rtl/dspd_pkg.sv
// Shared types and constants for the dual side PID drive.
// Used by dspd_lane and dual_side_pid_drive; depends on nothing else.
package dspd_pkg;

	localparam int INTEGRAL_WIDTH_DEF = 48;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LEFT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_RIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OUTPUT   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLAMP_ENABLE = 3'd7;

	localparam logic signed [15:0] MAX_OUTPUT_RST = 16'sh7fff;
	localparam logic signed [15:0] DRIVE_MAX      = 16'sh7fff;
	localparam logic signed [15:0] DRIVE_MIN      = 16'sh8000;

	// Magnitude limit of the integral product.
	localparam logic [59:0] PROD_CAP = 60'd1 << 59;

	typedef struct packed {
		logic [23:0]        gain_p;
		logic [23:0]        gain_i;
		logic [23:0]        gain_d;
		logic [30:0]        tolerance;
		logic signed [15:0] max_output;
		logic               clamp_enable;
	} lane_cfg_t;

endpackage

### hw/rtl/dspd_lane.sv
// One PID lane: error, saturating integral, derivative, products and drive.
// Depends on dspd_pkg for the lane settings type and constants.
module dspd_lane #(
	parameter int INTEGRAL_WIDTH = dspd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                step,
	input  logic                start,
	input  logic                hold,
	input  logic signed [31:0]  target,
	input  logic signed [31:0]  position,
	input  dspd_pkg::lane_cfg_t cfg,
	output logic                done,
	output logic                arrived,
	output logic signed [15:0]  drive
);

	localparam int IW = INTEGRAL_WIDTH;

	logic signed [IW-1:0] integ_q;
	logic signed [31:0]   last_q;
	logic                 done_q;

	logic signed [32:0]   err;
	logic [32:0]          err_mag;
	logic                 in_band;
	logic signed [31:0]   err_sat;
	logic signed [IW-1:0] integ_base;
	logic signed [31:0]   last_base;
	logic                 done_base;
	logic signed [IW:0]   integ_sum;
	logic signed [IW-1:0] integ_next;
	logic signed [32:0]   delta;

	logic signed [31:0]   err_s2;
	logic signed [IW-1:0] integ_s2;
	logic signed [32:0]   delta_s2;
	logic                 band_s2;
	logic                 arrived_s2;

	logic [IW-1:0]        imag;
	logic [63:0]          imag_w;

	logic signed [56:0]   pp_s3;
	logic signed [57:0]   pd_s3;
	logic [55:0]          ilo_s3;
	logic [55:0]          ihi_s3;
	logic                 ineg_s3;
	logic                 band_s3;
	logic                 arrived_s3;

	logic                 ihi_big;
	logic [59:0]          ifull;
	logic [59:0]          icap;

	logic signed [58:0]   pdsum_s4;
	logic signed [60:0]   icap_s4;
	logic                 band_s4;
	logic                 arrived_s4;

	logic signed [61:0]   total;
	logic signed [29:0]   quo;
	logic signed [15:0]   sat;
	logic signed [15:0]   law;

	always_comb begin
		err = $signed({target[31], target}) - $signed({position[31], position});
		err_mag = err[32] ? 33'(-err) : 33'(err);
		in_band = err_mag <= {2'b00, cfg.tolerance};
		if (err[32] != err[31]) begin
			err_sat = err[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			err_sat = err[31:0];
		end
		integ_base = start ? '0 : integ_q;
		last_base = start ? '0 : last_q;
		done_base = start ? 1'b0 : done_q;
		integ_sum = $signed({integ_base[IW-1], integ_base}) + (IW+1)'(err_sat);
		if (integ_sum[IW] != integ_sum[IW-1]) begin
			integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		end else begin
			integ_next = integ_sum[IW-1:0];
		end
		delta = $signed({err_sat[31], err_sat}) - $signed({last_base[31], last_base});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q <= '0;
			done_q <= 1'b0;
		end else if (step && !hold) begin
			integ_q <= integ_next;
			last_q <= err_sat;
			done_q <= done_base | in_band;
		end
	end

	assign done = done_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2 <= err_sat;
			integ_s2 <= integ_next;
			delta_s2 <= delta;
			band_s2 <= in_band;
			arrived_s2 <= done_base | in_band;
		end
	end

	always_comb begin
		imag = integ_s2[IW-1] ? IW'(-integ_s2) : IW'(integ_s2);
		imag_w = 64'(imag);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s3 <= $signed({1'b0, cfg.gain_p}) * err_s2;
			pd_s3 <= $signed({1'b0, cfg.gain_d}) * delta_s2;
			ilo_s3 <= cfg.gain_i * imag_w[31:0];
			ihi_s3 <= cfg.gain_i * imag_w[63:32];
			ineg_s3 <= integ_s2[IW-1];
			band_s3 <= band_s2;
			arrived_s3 <= arrived_s2;
		end
	end

	always_comb begin
		ihi_big = |ihi_s3[55:27];
		ifull = 60'({ihi_s3[26:0], 32'h0}) + 60'(ilo_s3);
		icap = (ihi_big || ifull > dspd_pkg::PROD_CAP) ? dspd_pkg::PROD_CAP : ifull;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pdsum_s4 <= 59'(pp_s3) + 59'(pd_s3);
			icap_s4 <= ineg_s3 ? -$signed({1'b0, icap}) : $signed({1'b0, icap});
			band_s4 <= band_s3;
			arrived_s4 <= arrived_s3;
		end
	end

	always_comb begin
		total = 62'(pdsum_s4) + 62'(icap_s4);
		quo = total[61:32];
		if (quo > 30'sd32767) begin
			sat = dspd_pkg::DRIVE_MAX;
		end else if (quo < -30'sd32768) begin
			sat = dspd_pkg::DRIVE_MIN;
		end else begin
			sat = quo[15:0];
		end
		law = band_s4 ? 16'sd0 : sat;
		if (cfg.clamp_enable && law >= cfg.max_output) begin
			drive = cfg.max_output;
		end else begin
			drive = law;
		end
	end

	assign arrived = arrived_s4;

endmodule

### hw/rtl/dual_side_pid_drive.sv
// Top level of the dual side PID drive: configuration registers, pipeline
// control and the output register. Depends on dspd_pkg and dspd_lane.
//
// Each input transfer on the s_axis channel is one control tick: tdata holds
// the left and right measured positions and tuser the start request. Each
// tick yields exactly one result transfer on m_axis with both drive commands
// in tdata and the arrival flags and the done flag in tuser.
// Registers are written on the cfg channel, which is always ready; they are
// meant to change only while no tick is in flight.
// The datapath has five register stages: input, error, product, sum and
// output. One tick per cycle is sustained while the receiver does not stall;
// the lane state (integral, previous error, arrival flag) is updated from the
// input stage, and the products and the final sum occupy the later stages.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and s_axis_tready drops until that result is taken.
// Reset clears the lane state and the pipeline, and loads the register reset
// values (zero, except a maximum output of 32767).
module dual_side_pid_drive #(
	parameter int INTEGRAL_WIDTH = dspd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// position_left [31:0], position_right [63:32]
	input  logic [63:0]                         s_axis_tdata,
	// start_req [0]
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// drive_left [15:0], drive_right [31:16]
	output logic [31:0]                         m_axis_tdata,
	// arrived_left [0], arrived_right [1], move_done [2]
	output logic [2:0]                          m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dspd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dspd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic signed [31:0]  target_left_q;
	logic signed [31:0]  target_right_q;
	dspd_pkg::lane_cfg_t lane_cfg_q;

	logic               adv;
	logic               step;
	logic               hold;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               start_s1;
	logic signed [31:0] pos_l_s1;
	logic signed [31:0] pos_r_s1;

	logic               done_l, done_r;
	logic               arr_l, arr_r;
	logic signed [15:0] drive_l, drive_r;
	logic               both;

	logic               out_valid_q;
	logic [31:0]        out_data_q;
	logic [2:0]         out_user_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_left_q <= '0;
			target_right_q <= '0;
			lane_cfg_q.gain_p <= '0;
			lane_cfg_q.gain_i <= '0;
			lane_cfg_q.gain_d <= '0;
			lane_cfg_q.tolerance <= '0;
			lane_cfg_q.max_output <= dspd_pkg::MAX_OUTPUT_RST;
			lane_cfg_q.clamp_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dspd_pkg::CFG_TARGET_LEFT: begin
					target_left_q <= cfg_data;
				end
				dspd_pkg::CFG_TARGET_RIGHT: begin
					target_right_q <= cfg_data;
				end
				dspd_pkg::CFG_GAIN_P: begin
					lane_cfg_q.gain_p <= cfg_data[23:0];
				end
				dspd_pkg::CFG_GAIN_I: begin
					lane_cfg_q.gain_i <= cfg_data[23:0];
				end
				dspd_pkg::CFG_GAIN_D: begin
					lane_cfg_q.gain_d <= cfg_data[23:0];
				end
				dspd_pkg::CFG_TOLERANCE: begin
					lane_cfg_q.tolerance <= cfg_data[30:0];
				end
				dspd_pkg::CFG_MAX_OUTPUT: begin
					lane_cfg_q.max_output <= cfg_data[15:0];
				end
				dspd_pkg::CFG_CLAMP_ENABLE: begin
					lane_cfg_q.clamp_enable <= cfg_data[0];
				end
			endcase
		end
	end

	assign adv = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign step = adv && v_s1;
	// Once both sides have arrived, further ticks without a start request leave the state untouched.
	assign hold = !start_s1 && done_l && done_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_s1 <= s_axis_tuser[0];
			pos_l_s1 <= s_axis_tdata[31:0];
			pos_r_s1 <= s_axis_tdata[63:32];
		end
	end

	dspd_lane #(
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.step    (step),
		.start   (start_s1),
		.hold    (hold),
		.target  (target_left_q),
		.position(pos_l_s1),
		.cfg     (lane_cfg_q),
		.done    (done_l),
		.arrived (arr_l),
		.drive   (drive_l)
	);

	dspd_lane #(
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.step    (step),
		.start   (start_s1),
		.hold    (hold),
		.target  (target_right_q),
		.position(pos_r_s1),
		.cfg     (lane_cfg_q),
		.done    (done_r),
		.arrived (arr_r),
		.drive   (drive_r)
	);

	assign both = arr_l && arr_r;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= both ? 32'h0 : {drive_r, drive_l};
			out_user_q <= {both, arr_r, arr_l};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

	a_done_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == 32'h0)
		else $error("Drive is not zero after both sides arrived.");

	a_done_both_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == 2'b11)
		else $error("Move done is set without both arrival flags.");

	a_left_latched: assert property (@(posedge clk) disable iff (!arst_n)
		step && !start_s1 && done_l |=> done_l)
		else $error("Left arrival flag cleared without a start request.");

	a_right_latched: assert property (@(posedge clk) disable iff (!arst_n)
		step && !start_s1 && done_r |=> done_r)
		else $error("Right arrival flag cleared without a start request.");

endmodule

### test/dual_side_pid_drive_tb.sv
// Self-checking testbench for dual_side_pid_drive: control ticks go in on the
// stream input, drive commands and arrival flags are checked against a PID predictor.
// Depends on dspd_pkg and the dual_side_pid_drive RTL.
module dual_side_pid_drive_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int INTEG_W = dspd_pkg::INTEGRAL_WIDTH_DEF;
	localparam int IDX_W = dspd_pkg::CFG_INDEX_W;
	localparam longint ERR_MAX = 64'sd2147483647;
	localparam longint ERR_MIN = -64'sd2147483648;
	localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
	localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic               start;
		logic signed [31:0] pos_l;
		logic signed [31:0] pos_r;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] drive_l;
		logic signed [15:0] drive_r;
		logic               arr_l;
		logic               arr_r;
		logic               both;
	} drive_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [dspd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	tick_t tick_queue[$];
	drive_cmd_t drive_due[$];
	int fails = 0;
	bit idle_on = 1'b1;
	int src_gap = 0;
	int hold_left = 0;
	int stall_asks = 0;
	int stall_served = 0;

	int cfg_target[2] = '{0, 0};
	logic [23:0] cfg_kp = '0;
	logic [23:0] cfg_ki = '0;
	logic [23:0] cfg_kd = '0;
	logic [30:0] cfg_tol = '0;
	shortint cfg_max_out = 16'sh7fff;
	bit cfg_clamp = 1'b0;

	longint integ_acc[2] = '{0, 0};
	longint prev_err[2] = '{0, 0};
	bit arrived[2] = '{1'b0, 1'b0};

	dual_side_pid_drive #(
		.INTEGRAL_WIDTH(INTEG_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint capped_product(input logic [23:0] k, input longint s);
		logic [95:0] m;
		logic [95:0] p;
		m = (s < 0) ? 96'(-s) : 96'(s);
		p = 96'(k) * m;
		if (p > 96'(dspd_pkg::PROD_CAP))
			p = 96'(dspd_pkg::PROD_CAP);
		return (s < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic logic signed [15:0] lane_drive(input int side, input longint pos);
		longint err, mag, es, delta, total, d, tol_l, kp_l, kd_l, lim;
		err = longint'(cfg_target[side]) - pos;
		mag = (err < 0) ? -err : err;
		es = (err > ERR_MAX) ? ERR_MAX : ((err < ERR_MIN) ? ERR_MIN : err);
		integ_acc[side] += es;
		if (integ_acc[side] > INTEG_MAX)
			integ_acc[side] = INTEG_MAX;
		if (integ_acc[side] < INTEG_MIN)
			integ_acc[side] = INTEG_MIN;
		delta = es - prev_err[side];
		prev_err[side] = es;
		tol_l = cfg_tol;
		kp_l = cfg_kp;
		kd_l = cfg_kd;
		if (mag <= tol_l) begin
			arrived[side] = 1'b1;
			d = 0;
		end else begin
			total = kp_l * es + capped_product(cfg_ki, integ_acc[side]) + kd_l * delta;
			d = total >>> 32;
			if (d > 32767)
				d = 32767;
			if (d < -32768)
				d = -32768;
		end
		lim = cfg_max_out;
		if (cfg_clamp && d >= lim)
			d = lim;
		return 16'(d);
	endfunction

	function automatic void pid_tick(input logic start, input logic signed [31:0] pl,
			input logic signed [31:0] pr);
		drive_cmd_t r;
		if (start) begin
			integ_acc = '{0, 0};
			prev_err = '{0, 0};
			arrived = '{1'b0, 1'b0};
		end
		r = '0;
		if (!(arrived[0] && arrived[1])) begin
			r.drive_l = lane_drive(0, longint'(pl));
			r.drive_r = lane_drive(1, longint'(pr));
		end
		r.arr_l = arrived[0];
		r.arr_r = arrived[1];
		r.both = arrived[0] && arrived[1];
		if (r.both) begin
			r.drive_l = '0;
			r.drive_r = '0;
		end
		drive_due.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		tick_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pid_tick(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (tick_queue.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(0, 18);
					s_axis_tvalid <= 1'b0;
				end else begin
					nxt = tick_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {nxt.pos_r, nxt.pos_l};
					s_axis_tuser <= nxt.start;
				end
			end
		end
	end

	always @(posedge clk) begin
		drive_cmd_t due;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_due.size() == 0) begin
					$error("result transfer with no tick outstanding");
					fails++;
				end else begin
					due = drive_due.pop_front();
					check_field("drive_left", due.drive_l, $signed(m_axis_tdata[15:0]));
					check_field("drive_right", due.drive_r, $signed(m_axis_tdata[31:16]));
					check_field("arrived_left", due.arr_l, m_axis_tuser[0]);
					check_field("arrived_right", due.arr_r, m_axis_tuser[1]);
					check_field("move_done", due.both, m_axis_tuser[2]);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_asks != stall_served) begin
				stall_served++;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(0, 18);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dspd_pkg::CFG_TARGET_LEFT: cfg_target[0] = data;
			dspd_pkg::CFG_TARGET_RIGHT: cfg_target[1] = data;
			dspd_pkg::CFG_GAIN_P: cfg_kp = data[23:0];
			dspd_pkg::CFG_GAIN_I: cfg_ki = data[23:0];
			dspd_pkg::CFG_GAIN_D: cfg_kd = data[23:0];
			dspd_pkg::CFG_TOLERANCE: cfg_tol = data[30:0];
			dspd_pkg::CFG_MAX_OUTPUT: cfg_max_out = data[15:0];
			dspd_pkg::CFG_CLAMP_ENABLE: cfg_clamp = data[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (tick_queue.size() != 0 || s_axis_tvalid || drive_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void push_tick(input logic start, input logic [31:0] pl,
			input logic [31:0] pr);
		tick_t t;
		t.start = start;
		t.pos_l = pl;
		t.pos_r = pr;
		tick_queue.push_back(t);
	endfunction

	function automatic logic [31:0] pick_value(input logic [IDX_W-1:0] idx);
		logic [31:0] v;
		v = $urandom;
		case (idx)
			dspd_pkg::CFG_TARGET_LEFT, dspd_pkg::CFG_TARGET_RIGHT: begin
				case ($urandom_range(0, 5))
					0: v = 32'h7fffffff;
					1: v = 32'h80000000;
					2: v = '0;
					default: ;
				endcase
			end
			dspd_pkg::CFG_GAIN_P, dspd_pkg::CFG_GAIN_I, dspd_pkg::CFG_GAIN_D: begin
				case ($urandom_range(0, 7))
					0: v[23:0] = '0;
					1: v[23:0] = '1;
					default: v[23:0] = v[23:0] >> $urandom_range(0, 23);
				endcase
			end
			dspd_pkg::CFG_TOLERANCE: begin
				case ($urandom_range(0, 7))
					0: v[30:0] = '0;
					1: v[30:0] = '1;
					default: v[30:0] = v[30:0] >> $urandom_range(0, 30);
				endcase
			end
			dspd_pkg::CFG_MAX_OUTPUT: begin
				case ($urandom_range(0, 4))
					0: v[15:0] = 16'h8000;
					1: v[15:0] = 16'h7fff;
					2: v[15:0] = '0;
					default: v[15:0] = 16'($urandom_range(0, 8000)) - 16'd4000;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic longint rand_offset();
		longint m;
		m = longint'($urandom >> $urandom_range(0, 31));
		if ($urandom_range(0, 1) != 0)
			m = -m;
		return m;
	endfunction

	// One move: a start, positions closing in on both targets, then a few ticks on target.
	function automatic int add_move(input int len);
		longint off_l, off_r;
		int settle;
		off_l = rand_offset();
		off_r = rand_offset();
		settle = $urandom_range(1, 4);
		for (int i = 0; i < len; i++) begin
			push_tick(i == 0, 32'(longint'(cfg_target[0]) - off_l),
				32'(longint'(cfg_target[1]) - off_r));
			off_l = off_l * longint'($urandom_range(30, 95)) / 100;
			off_r = off_r * longint'($urandom_range(30, 95)) / 100;
			if ($urandom_range(0, 7) == 0)
				off_l += rand_offset() >>> 8;
			if ($urandom_range(0, 7) == 0)
				off_r += rand_offset() >>> 8;
		end
		for (int i = 0; i < settle; i++)
			push_tick(1'b0, cfg_target[0], cfg_target[1]);
		return len + settle;
	endfunction

	task automatic fill_phase(input int n);
		int pushed;
		pushed = 0;
		while (pushed < n) begin
			if ($urandom_range(0, 9) == 0) begin
				push_tick($urandom_range(0, 15) == 0, $urandom, $urandom);
				pushed++;
			end else begin
				pushed += add_move($urandom_range(3, 30));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(dspd_pkg::CFG_TARGET_LEFT, 32'h7fffffff);
		write_reg(dspd_pkg::CFG_TARGET_RIGHT, 32'h80000000);
		write_reg(dspd_pkg::CFG_GAIN_P, 32'h00ffffff);
		write_reg(dspd_pkg::CFG_GAIN_I, 32'h00ffffff);
		write_reg(dspd_pkg::CFG_GAIN_D, 32'h00ffffff);
		write_reg(dspd_pkg::CFG_TOLERANCE, 32'h00000000);
		write_reg(dspd_pkg::CFG_MAX_OUTPUT, 32'h00007fff);
		write_reg(dspd_pkg::CFG_CLAMP_ENABLE, 32'h00000000);
		// Full-scale errors of both signs until the integral product hits its cap.
		push_tick(1'b1, 32'h80000000, 32'h7fffffff);
		for (int i = 0; i < 16; i++)
			push_tick(1'b0, 32'h80000000, 32'h7fffffff);
		// Left arrives, then leaves the band while the right side arrives last.
		push_tick(1'b0, 32'h7fffffff, 32'h00000000);
		push_tick(1'b0, 32'h7ffffff0, 32'h80000000);
		push_tick(1'b0, 32'h00000000, 32'h00000000);
		push_tick(1'b1, 32'h7fffffff, 32'h80000000);
		drain();

		write_reg(dspd_pkg::CFG_TOLERANCE, 32'hffffffff);
		write_reg(dspd_pkg::CFG_MAX_OUTPUT, 32'hffffff9c);
		write_reg(dspd_pkg::CFG_CLAMP_ENABLE, 32'hffffffff);
		push_tick(1'b1, 32'h80000000, 32'h00000000);
		push_tick(1'b1, 32'h7fffffff, 32'h00000000);
		push_tick(1'b0, 32'h7fffffff, 32'h80000000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 8; r++)
				if (ph == 0 || $urandom_range(0, 2) != 0)
					write_reg(IDX_W'(r), pick_value(IDX_W'(r)));
			idle_on = (ph == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
			fill_phase(205);
			if (ph == 3)
				stall_asks++;
			drain();
		end

		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/dspd_pkg.sv
hw/rtl/dspd_lane.sv
hw/rtl/dual_side_pid_drive.sv
test/dual_side_pid_drive_tb.sv
